/* hdl/psg_pkg.sv */
// Shared types and constants for the programmable sound generator tone core.
`default_nettype none

package psg_pkg;

  localparam int unsigned PeriodW = 10;
  localparam int unsigned VolW    = 4;
  localparam int unsigned ChIdxW  = 2;
  localparam int unsigned MixW    = 7;
  localparam int unsigned ByteW   = 8;

  // Register byte layout.
  localparam int unsigned LatchFlagBit = 7;
  localparam int unsigned ChSelHi      = 6;
  localparam int unsigned ChSelLo      = 5;
  localparam int unsigned TypeBit      = 4;
  localparam int unsigned LowNibbleW   = 4;
  localparam int unsigned HighBitsW    = 6;

  // Mode codes carried on the input tuser bit.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  // One request as seen by the state-holding units.
  typedef struct packed {
    logic             wr_en;
    logic             tick_en;
    logic [ByteW-1:0] wr_byte;
  } psg_cmd_t;

endpackage : psg_pkg

`default_nettype wire

/* hdl/psg_tone_generator_core.sv */
// Top level of the three-channel square-wave tone generator.
//
//  channel  | tvalid/tready | tuser       | tdata
//  s_axis   | request in    | [0] mode    | [7:0] data_byte
//  m_axis   | result out    | -           | [6:0] mix_sample, [7] zero
//
// Each request is registered in the input register, then applied to the state
// and mixed into the output register once that register is free or being read,
// and its result is offered from the output register.
// One request per cycle is sustained; the only limit is the output register.
// Reset clears the state registers, polarity to positive and the latch to
// channel 0 tone. A stalled output holds its result while one more request
// is buffered.
`default_nettype none

module psg_tone_generator_core
  import psg_pkg::*;
#(
  parameter int unsigned TONE_CHANNELS = 3
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  wire logic [7:0]       s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic [0:0]       s_axis_tuser_i,   // [0] mode
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  output logic [7:0]            m_axis_tdata_o    // [6:0] mix_sample, [7] zero
);

  logic             in_valid_q;
  logic             in_mode_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q, out_valid_d;
  logic             s_fire;
  logic             exec;
  psg_cmd_t         cmd;

  logic [TONE_CHANNELS-1:0][PeriodW-1:0] period;
  logic [TONE_CHANNELS-1:0][VolW-1:0]    vol_next;
  logic [TONE_CHANNELS-1:0]              active_next;
  logic [TONE_CHANNELS-1:0]              neg_next;
  logic signed [MixW-1:0]                mix;

  assign exec            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || exec;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_mode_q <= s_axis_tuser_i[0];
      in_byte_q <= s_axis_tdata_i;
    end
  end

  assign cmd = '{wr_en:   exec && (in_mode_q == MODE_WRITE),
                 tick_en: exec && (in_mode_q == MODE_TICK),
                 wr_byte: in_byte_q};

  psg_regs #(.NumCh(TONE_CHANNELS)) u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .period_o   (period),
    .vol_next_o (vol_next)
  );

  psg_tone #(.NumCh(TONE_CHANNELS)) u_tone (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .period_i      (period),
    .active_next_o (active_next),
    .neg_next_o    (neg_next)
  );

  psg_mixer #(.NumCh(TONE_CHANNELS)) u_mixer (
    .clk_i    (clk_i),
    .load_i   (exec),
    .active_i (active_next),
    .neg_i    (neg_next),
    .vol_i    (vol_next),
    .mix_o    (mix)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, mix};

endmodule : psg_tone_generator_core

`default_nettype wire

/* hdl/psg_regs.sv */
// Latch/data register decode with the period, volume and latch registers.
`default_nettype none

module psg_regs
  import psg_pkg::*;
#(
  parameter int unsigned NumCh = 3
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire psg_cmd_t                           cmd_i,
  output logic      [NumCh-1:0][PeriodW-1:0]      period_o,
  output logic      [NumCh-1:0][VolW-1:0]         vol_next_o
);

  logic [ChIdxW-1:0] latch_ch_q, latch_ch_d;
  logic              latch_vol_q, latch_vol_d;
  logic              is_latch;
  logic [ChIdxW-1:0] tgt_ch;
  logic              tgt_vol;

  logic [NumCh-1:0][PeriodW-1:0] period_q, period_d;
  logic [NumCh-1:0][VolW-1:0]    vol_q, vol_d;

  assign is_latch = cmd_i.wr_byte[LatchFlagBit];

  always_comb begin
    latch_ch_d  = latch_ch_q;
    latch_vol_d = latch_vol_q;
    if (cmd_i.wr_en && is_latch) begin
      latch_ch_d  = cmd_i.wr_byte[ChSelHi:ChSelLo];
      latch_vol_d = cmd_i.wr_byte[TypeBit];
    end
  end

  // A latch byte retargets before its own nibble is written.
  assign tgt_ch  = latch_ch_d;
  assign tgt_vol = latch_vol_d;

  always_comb begin
    period_d = period_q;
    vol_d    = vol_q;
    for (int unsigned i = 0; i < NumCh; i++) begin
      if (cmd_i.wr_en && (tgt_ch == ChIdxW'(i))) begin
        if (tgt_vol) begin
          vol_d[i] = cmd_i.wr_byte[VolW-1:0];
        end else if (is_latch) begin
          period_d[i][LowNibbleW-1:0] = cmd_i.wr_byte[LowNibbleW-1:0];
        end else begin
          period_d[i][PeriodW-1:LowNibbleW] = cmd_i.wr_byte[HighBitsW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_ch_q  <= '0;
      latch_vol_q <= 1'b0;
      period_q    <= '0;
      vol_q       <= '0;
    end else begin
      latch_ch_q  <= latch_ch_d;
      latch_vol_q <= latch_vol_d;
      period_q    <= period_d;
      vol_q       <= vol_d;
    end
  end

  assign period_o   = period_q;
  assign vol_next_o = vol_d;

endmodule : psg_regs

`default_nettype wire

/* hdl/psg_tone.sv */
// Per-channel down counters and square-wave polarity flops.
`default_nettype none

module psg_tone
  import psg_pkg::*;
#(
  parameter int unsigned NumCh = 3
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire psg_cmd_t                       cmd_i,
  input  wire logic [NumCh-1:0][PeriodW-1:0]  period_i,
  output logic      [NumCh-1:0]               active_next_o,
  output logic      [NumCh-1:0]               neg_next_o
);

  logic [NumCh-1:0][PeriodW-1:0] cnt_q, cnt_d;
  logic [NumCh-1:0]              pol_q, pol_d;

  always_comb begin
    cnt_d = cnt_q;
    pol_d = pol_q;
    for (int unsigned i = 0; i < NumCh; i++) begin
      if (cmd_i.tick_en) begin
        if (cnt_q[i] != '0) begin
          cnt_d[i] = cnt_q[i] - PeriodW'(1);
        end else begin
          cnt_d[i] = period_i[i];
          pol_d[i] = ~pol_q[i];
        end
      end
      active_next_o[i] = (cnt_d[i] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      pol_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      pol_q <= pol_d;
    end
  end

  assign neg_next_o = pol_d;

endmodule : psg_tone

`default_nettype wire

/* hdl/psg_mixer.sv */
// Signed channel mix and the result register.
`default_nettype none

module psg_mixer
  import psg_pkg::*;
#(
  parameter int unsigned NumCh = 3
) (
  input  wire logic                        clk_i,
  input  wire logic                        load_i,
  input  wire logic [NumCh-1:0]            active_i,
  input  wire logic [NumCh-1:0]            neg_i,
  input  wire logic [NumCh-1:0][VolW-1:0]  vol_i,
  output logic signed [MixW-1:0]           mix_o
);

  logic signed [MixW-1:0] sum;
  logic signed [MixW-1:0] level;
  logic signed [MixW-1:0] mix_q;

  // Fifteen minus the volume is the bitwise inverse of the 4-bit volume.
  always_comb begin
    sum   = '0;
    level = '0;
    for (int unsigned i = 0; i < NumCh; i++) begin
      level = $signed({{(MixW-VolW){1'b0}}, ~vol_i[i]});
      if (active_i[i]) begin
        sum = neg_i[i] ? (sum - level) : (sum + level);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      mix_q <= sum;
    end
  end

  assign mix_o = mix_q;

endmodule : psg_mixer

`default_nettype wire

/* hdl/psg_chk.sv */
// Port-level checker for the tone generator, bound to the top level.
`default_nettype none

module psg_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_tvalid_i,
  input wire logic       s_tready_i,
  input wire logic       m_tvalid_i,
  input wire logic       m_tready_i,
  input wire logic [7:0] m_tdata_i
);

  // A stalled result must stay offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> $stable(m_tdata_i))
    else $error("result changed while stalled");

  // With the sink ready in the next cycle, a request passes the input and output registers to the output.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i ##1 m_tready_i |=> m_tvalid_i)
    else $error("result missing after request");

  // The limits are those of four channels at full level; the pad bit is always zero.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> (m_tdata_i[7] == 1'b0) &&
      ($signed(m_tdata_i[6:0]) >= -7'sd60) && ($signed(m_tdata_i[6:0]) <= 7'sd60))
    else $error("mix out of range");

endmodule : psg_chk

bind psg_tone_generator_core psg_chk u_psg_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o)
);

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the three-channel tone generator core.
`timescale 1ns / 1ps

module tb_top
  import psg_pkg::*;
();

  localparam int unsigned TONE_CHANNELS = 3;

  typedef struct {
    logic             mode;
    logic [ByteW-1:0] data_byte;
  } psg_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic             src_valid = 1'b0;
  logic             src_mode = MODE_WRITE;
  logic [ByteW-1:0] src_byte = '0;
  logic             sink_ready = 1'b0;
  logic             s_axis_tready_o;
  logic             m_axis_tvalid_o;
  logic [7:0]       m_axis_tdata_o;

  psg_req_t               pending_reqs[$];
  logic signed [MixW-1:0] mix_expected[$];
  int unsigned            mismatch_cnt = 0;
  int unsigned            burst_left = 0;
  int unsigned            gap_left = 0;
  int unsigned            run_left = 0;
  int unsigned            stall_left = 0;

  // Shadow copy of the generator state.
  logic [PeriodW-1:0] period_sh[4];
  logic [VolW-1:0]    vol_sh[4];
  logic [PeriodW-1:0] count_sh[TONE_CHANNELS];
  logic               neg_sh[TONE_CHANNELS];
  logic [ChIdxW-1:0]  latch_ch_sh;
  logic               latch_vol_sh;

  psg_tone_generator_core #(
    .TONE_CHANNELS(TONE_CHANNELS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(src_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (src_byte),   // [7:0] data_byte
    .s_axis_tuser_i (src_mode),   // [0] mode
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(sink_ready),
    .m_axis_tdata_o (m_axis_tdata_o)  // [6:0] mix_sample, [7] zero
  );

  always #5 clk_i = ~clk_i;

  // Applies one request to the shadow state and returns the mix that follows it.
  function automatic logic signed [MixW-1:0] mix_after(logic mode, logic [ByteW-1:0] b);
    int sum;
    int level;
    if (mode == MODE_TICK) begin
      for (int c = 0; c < TONE_CHANNELS; c++) begin
        if (count_sh[c] != '0) begin
          count_sh[c] = count_sh[c] - PeriodW'(1);
        end else begin
          count_sh[c] = period_sh[c];
          neg_sh[c]   = ~neg_sh[c];
        end
      end
    end else if (b[LatchFlagBit]) begin
      latch_ch_sh  = b[ChSelHi:ChSelLo];
      latch_vol_sh = b[TypeBit];
      if (latch_vol_sh) vol_sh[latch_ch_sh] = b[VolW-1:0];
      else period_sh[latch_ch_sh][LowNibbleW-1:0] = b[LowNibbleW-1:0];
    end else begin
      if (latch_vol_sh) vol_sh[latch_ch_sh] = b[VolW-1:0];
      else period_sh[latch_ch_sh][PeriodW-1:LowNibbleW] = b[HighBitsW-1:0];
    end
    sum = 0;
    for (int c = 0; c < TONE_CHANNELS; c++) begin
      if (count_sh[c] != '0) begin
        level = 15 - int'(vol_sh[c]);
        sum += neg_sh[c] ? -level : level;
      end
    end
    return sum[MixW-1:0];
  endfunction

  task automatic add_req(input logic mode, input logic [ByteW-1:0] b);
    psg_req_t r;
    r.mode      = mode;
    r.data_byte = b;
    pending_reqs.push_back(r);
  endtask

  // Request driver: bursts of random length separated by random gaps.
  always @(posedge clk_i) begin
    logic fire;
    if (!rst_ni) begin
      src_valid <= 1'b0;
    end else begin
      fire = src_valid && s_axis_tready_o;
      if (fire) begin
        mix_expected.push_back(mix_after(src_mode, src_byte));
        pending_reqs.pop_front();
      end
      if (!src_valid || fire) begin
        if (gap_left != 0) begin
          gap_left--;
          src_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          src_valid <= 1'b1;
          src_mode  <= pending_reqs[0].mode;
          src_byte  <= pending_reqs[0].data_byte;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // Result sink with its own stall pattern.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sink_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
      if (run_left > 1) begin
        run_left--;
      end else begin
        run_left   = $urandom_range(1, 30);
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    logic signed [MixW-1:0] want;
    logic signed [MixW-1:0] got;
    if (rst_ni && m_axis_tvalid_o && sink_ready) begin
      got = m_axis_tdata_o[MixW-1:0];
      if (mix_expected.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: result with nothing pending, expected none, actual mix_sample %0d",
                 $realtime, got);
      end else begin
        want = mix_expected.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          $display("%0t: mix_sample mismatch, expected %0d, actual %0d",
                   $realtime, want, got);
        end
      end
    end
  end

  initial begin
    logic [1:0] ch;
    logic       is_vol;
    int         seg;
    int         n;

    for (int i = 0; i < 4; i++) begin
      period_sh[i] = '0;
      vol_sh[i]    = '0;
    end
    for (int i = 0; i < TONE_CHANNELS; i++) begin
      count_sh[i] = '0;
      neg_sh[i]   = 1'b0;
    end
    latch_ch_sh  = '0;
    latch_vol_sh = 1'b0;

    // Directed part. A data byte right after reset goes to the tone of channel 0.
    add_req(MODE_WRITE, 8'h3F);
    add_req(MODE_TICK,  8'hFF);
    add_req(MODE_WRITE, 8'h8F);
    add_req(MODE_TICK,  8'h00);
    // Volume data byte with bits 5..4 set, which must be ignored.
    add_req(MODE_WRITE, 8'hB0);
    add_req(MODE_WRITE, 8'h3A);
    // Channel 3 is kept only in the shadow copy and never sounded.
    add_req(MODE_WRITE, 8'hE5);
    add_req(MODE_WRITE, 8'h2A);
    add_req(MODE_WRITE, 8'hFF);
    // Period zero on channel 2 toggles every tick without adding to the mix.
    add_req(MODE_WRITE, 8'hC0);
    add_req(MODE_WRITE, 8'h00);
    add_req(MODE_TICK,  8'h00);
    add_req(MODE_TICK,  8'h00);
    // Short equal periods and full volume on all channels, then a run of ticks.
    add_req(MODE_WRITE, 8'h85);
    add_req(MODE_WRITE, 8'h00);
    add_req(MODE_WRITE, 8'hA5);
    add_req(MODE_WRITE, 8'h00);
    add_req(MODE_WRITE, 8'hC5);
    add_req(MODE_WRITE, 8'h90);
    add_req(MODE_WRITE, 8'hB0);
    add_req(MODE_WRITE, 8'hD0);
    repeat (14) add_req(MODE_TICK, 8'h80);

    // Random part: mostly well-formed latch/data pairs and tick runs.
    while (pending_reqs.size() < 1435) begin
      seg = $urandom_range(0, 99);
      if (seg < 45) begin
        n = $urandom_range(1, 30);
        repeat (n) add_req(MODE_TICK, 8'($urandom));
      end else if (seg < 85) begin
        ch     = 2'($urandom_range(0, 3));
        is_vol = 1'($urandom_range(0, 1));
        add_req(MODE_WRITE, {1'b1, ch, is_vol, 4'($urandom)});
        if ($urandom_range(0, 3) != 0) begin
          if (is_vol) add_req(MODE_WRITE, {1'b0, 7'($urandom)});
          else if ($urandom_range(0, 4) == 0) add_req(MODE_WRITE, {2'b00, 6'($urandom)});
          else add_req(MODE_WRITE, {2'b00, 6'($urandom_range(0, 3))});
        end
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) add_req(MODE_WRITE, 8'($urandom));
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || src_valid) @(posedge clk_i);
    while (mix_expected.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
